// File: hw/rtl/bfies_pkg.sv
// Types and codes shared by the bit-field insert/extract store.
// Holds the request/response payload structs and the opcode set.
// No dependencies.
`default_nettype none

package bfies_pkg;

   // Operation codes carried by each request
   typedef enum logic [1:0] {
      OP_READ        = 2'd0,
      OP_WRITE       = 2'd1,
      OP_WRITE_ALIGN = 2'd2,
      OP_READ_ALIGN  = 2'd3
   } op_type;

   // Request payload
   typedef struct packed {
      op_type      opcode;
      logic [14:0] bit_index;
      logic [5:0]  bit_count;
      logic [31:0] write_value;
   } req_item_type;

   // Response payload
   typedef struct packed {
      logic [31:0] read_value;
      logic [15:0] next_index;
      logic        out_of_range;
   } rsp_item_type;

   // Store word geometry: 32-bit rows, MSB-first bit order
   localparam int WORD_BITS = 32;

endpackage

`default_nettype wire

// File: hw/rtl/bit_field_insert_extract_store.sv
// Top level of the MSB-first bit-field insert/extract store.
// Depends on bfies_pkg (payload types, opcodes) and bfies_ram (two store banks).
`default_nettype none

// The store is STORE_BYTES bytes addressed by bit index, bit 0 being the MSB of
// byte 0. It is kept as 32-bit words split over two RAM banks (even words and
// odd words), so any field of up to 32 bits, which touches at most two adjacent
// words, is read from both banks at once and written back to both at once. In
// the transfer cycle the block issues the reads of both words; the merge state
// then merges the field and, for a write op, writes the banks while the response is
// loaded into the output register. A new request is taken only after the
// previous write-back, so every read sees all earlier writes. A response that
// is held by rsp_stall holds the merge step of the following item until the
// output register frees up, and no new request is taken during that wait.
// After reset the block clears both banks, one row of each per cycle, and
// takes no request during that pass. Accesses past the store end set
// out_of_range and leave the store untouched.
module bit_field_insert_extract_store #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bfies_pkg::req_item_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bfies_pkg::rsp_item_type     rsp_data
);

   import bfies_pkg::*;

   localparam int WORDS     = (STORE_BYTES + 3) / 4;
   localparam int BANK_ROWS = (WORDS + 1) / 2;
   localparam int RA        = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

   localparam logic [31:0] TOTAL_BITS  = 32'(8 * STORE_BYTES);
   localparam logic [31:0] WORDS_L     = 32'(WORDS);
   localparam logic [31:0] BANK_ROWS_L = 32'(BANK_ROWS);
   localparam logic [RA-1:0] LAST_ROW  = RA'(BANK_ROWS - 1);
   localparam logic [5:0]  MAX_CNT     = 6'(MAX_FIELD_BITS);

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [RA-1:0] clear_cnt_ff, clear_cnt_in;

   // Per-item registers captured at the request transfer
   op_type         op_ff;
   logic [5:0]     cnt_ff;
   logic [31:0]    val_ff;
   logic [4:0]     off_ff;
   logic [15:0]    next_ff;
   logic           oor_ff;
   logic           swap_ff;
   logic           wen0_ff, wen1_ff;
   logic [RA-1:0]  row0_ff, row1_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_data_ff;

   // Request decode
   logic        req_fire;
   logic [5:0]  cnt_sat, cnt_calc;
   logic [31:0] val_calc;
   logic [15:0] next_calc;
   logic        oor_calc;
   logic        is_write_calc;
   logic [9:0]  word_idx;
   logic [8:0]  half_row;
   logic [9:0]  row_second;
   logic        second_ok;
   logic        first_ok;
   logic [9:0]  row0_raw, row1_raw;
   logic        row0_ok, row1_ok;
   logic [RA-1:0] rd_addr0, rd_addr1;
   logic        wen_first, wen_second;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // Field length: saturate, or pad length for the align ops
   assign cnt_sat = (req_data.bit_count > MAX_CNT) ? MAX_CNT : req_data.bit_count;
   always_comb begin
      unique case (req_data.opcode)
         OP_WRITE_ALIGN, OP_READ_ALIGN: begin
            cnt_calc = {3'd0, 3'(3'd0 - req_data.bit_index[2:0])};
            val_calc = '0;
         end
         default: begin
            cnt_calc = cnt_sat;
            val_calc = req_data.write_value;
         end
      endcase
   end

   assign next_calc     = {1'b0, req_data.bit_index} + {10'd0, cnt_calc};
   assign oor_calc      = {16'd0, next_calc} > TOTAL_BITS;
   assign is_write_calc = (req_data.opcode == OP_WRITE) ||
                          (req_data.opcode == OP_WRITE_ALIGN);

   // Word rows: even words live in bank 0, odd words in bank 1
   assign word_idx   = req_data.bit_index[14:5];
   assign half_row   = word_idx[9:1];
   assign row_second = {1'b0, half_row} + 10'd1;
   assign second_ok  = ({22'd0, word_idx} + 32'd1) < WORDS_L;
   assign first_ok   = {22'd0, word_idx} < WORDS_L;
   assign row0_raw   = word_idx[0] ? row_second : {1'b0, half_row};
   assign row1_raw   = {1'b0, half_row};
   assign row0_ok    = {22'd0, row0_raw} < BANK_ROWS_L;
   assign row1_ok    = {22'd0, row1_raw} < BANK_ROWS_L;
   assign rd_addr0   = row0_ok ? RA'(row0_raw) : '0;
   assign rd_addr1   = row1_ok ? RA'(row1_raw) : '0;

   assign wen_first  = is_write_calc && !oor_calc && first_ok;
   assign wen_second = is_write_calc && !oor_calc && second_ok;

   // Bank read data and merge
   logic [31:0] rd0, rd1;
   logic [63:0] win_old, win_new;
   logic [6:0]  shift;
   logic [31:0] mask32;
   logic [63:0] mask64, data64;
   logic [31:0] field;
   logic        merge_go;

   assign win_old = swap_ff ? {rd1, rd0} : {rd0, rd1};
   assign shift   = 7'd64 - {2'd0, off_ff} - {1'b0, cnt_ff};
   assign mask32  = 32'((33'd1 << cnt_ff) - 33'd1);
   assign mask64  = {32'd0, mask32} << shift;
   assign data64  = {32'd0, val_ff & mask32} << shift;
   assign win_new = (win_old & ~mask64) | data64;
   assign field   = 32'(win_old >> shift) & mask32;

   assign merge_go = (state_ff == ST_MERGE) && (!rsp_valid_ff || !rsp_stall);

   // Bank write ports: clear pass or write-back of the merged window
   logic          bank0_we, bank1_we;
   logic [RA-1:0] bank0_wa, bank1_wa;
   logic [31:0]   bank0_wd, bank1_wd;

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         bank0_we = 1'b1;
         bank1_we = 1'b1;
         bank0_wa = clear_cnt_ff;
         bank1_wa = clear_cnt_ff;
         bank0_wd = '0;
         bank1_wd = '0;
      end else begin
         bank0_we = merge_go && wen0_ff;
         bank1_we = merge_go && wen1_ff;
         bank0_wa = row0_ff;
         bank1_wa = row1_ff;
         bank0_wd = swap_ff ? win_new[31:0]  : win_new[63:32];
         bank1_wd = swap_ff ? win_new[63:32] : win_new[31:0];
      end
   end

   bfies_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BANK_ROWS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank0_we),
      .wr_addr (bank0_wa),
      .wr_data (bank0_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr0),
      .rd_data (rd0)
   );

   bfies_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BANK_ROWS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank1_we),
      .wr_addr (bank1_wa),
      .wr_data (bank1_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_addr1),
      .rd_data (rd1)
   );

   // Controller next state
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + RA'(1);
            if (clear_cnt_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (merge_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Item capture at the request transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_data.opcode;
         cnt_ff  <= cnt_calc;
         val_ff  <= val_calc;
         off_ff  <= req_data.bit_index[4:0];
         next_ff <= oor_calc ? {1'b0, req_data.bit_index} : next_calc;
         oor_ff  <= oor_calc;
         swap_ff <= word_idx[0];
         wen0_ff <= word_idx[0] ? wen_second : wen_first;
         wen1_ff <= word_idx[0] ? wen_first  : wen_second;
         row0_ff <= rd_addr0;
         row1_ff <= rd_addr1;
      end
   end

   // Output register
   assign rsp_valid_in = merge_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_go) begin
         rsp_data_ff.read_value   <= (op_ff == OP_READ && !oor_ff) ? field : '0;
         rsp_data_ff.next_index   <= next_ff;
         rsp_data_ff.out_of_range <= oor_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // An accepted request always moves on to the merge step
   a_fire_to_merge: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MERGE))
      else $error("request transfer not followed by merge");

   // Out-of-range items never touch the store
   a_oor_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && oor_ff) |-> (!bank0_we && !bank1_we))
      else $error("store written by out-of-range item");

   // Read ops never write the store
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE && (op_ff == OP_READ || op_ff == OP_READ_ALIGN))
      |-> (!bank0_we && !bank1_we))
      else $error("store written by read op");

   // A new response only appears right after a merge step
   a_rsp_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MERGE))
      else $error("response without merge");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bfies_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both banks of the bit-field store. No dependencies.
`default_nettype none

module bfies_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_bit_field_insert_extract_store.sv
// Self-checking testbench for bit_field_insert_extract_store.
// Keeps a byte-level shadow of the store, predicts every response and
// compares it field by field. Depends on bfies_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_bit_field_insert_extract_store;
   import bfies_pkg::*;

   localparam int STORE_BYTES = 4096;
   localparam int STORE_BITS  = STORE_BYTES * 8;
   localparam int FIELD_MAX   = 32;
   localparam int HOT_SPAN    = 512;
   localparam int TAIL_CYCLES = 16;
   localparam int HOLD_CYCLES = 400;

   // DUT ports
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // Traffic shaping knobs
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold = 1'b0;
   int   error_count = 0;

   // Shadow of the store and responses still owed by the block
   logic [7:0]   shadow_store [0:STORE_BYTES-1];
   rsp_item_type pending_results [$];
   rsp_item_type oldest_expected;

   bit_field_insert_extract_store u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one access to the shadow store and return the response it gives
   function automatic rsp_item_type apply_access(input req_item_type item);
      rsp_item_type result;
      int unsigned  count;
      int unsigned  stop;
      int unsigned  pos;
      result = '0;
      count = (item.bit_count > FIELD_MAX) ? FIELD_MAX : item.bit_count;
      if (item.opcode == OP_WRITE_ALIGN || item.opcode == OP_READ_ALIGN) begin
         count = (8 - item.bit_index[2:0]) & 7;
      end
      stop = item.bit_index + count;
      // past the end: no store change, index stays put
      if (stop > STORE_BITS) begin
         result.next_index   = {1'b0, item.bit_index};
         result.out_of_range = 1'b1;
         return result;
      end
      for (int k = 0; k < count; k++) begin
         pos = item.bit_index + k;
         case (item.opcode)
            OP_READ: begin
               result.read_value = {result.read_value[30:0],
                                    shadow_store[pos >> 3][7 - (pos & 7)]};
            end
            OP_WRITE: begin
               shadow_store[pos >> 3][7 - (pos & 7)] = item.write_value[count - 1 - k];
            end
            OP_WRITE_ALIGN: begin
               shadow_store[pos >> 3][7 - (pos & 7)] = 1'b0;
            end
            default: ;
         endcase
      end
      result.next_index = stop[15:0];
      return result;
   endfunction

   // One transfer on the request channel; starts and ends at a falling edge
   task automatic send_item(input req_item_type item);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_access(item));
      @(negedge clock);
   endtask

   task automatic send_op(input op_type op, input int unsigned idx,
                          input int unsigned cnt, input logic [31:0] val);
      req_item_type item;
      item.opcode      = op;
      item.bit_index   = 15'(idx);
      item.bit_count   = 6'(cnt);
      item.write_value = val;
      send_item(item);
   endtask

   // Random access, biased toward the two ends of the store so fields overlap
   function automatic req_item_type random_access();
      req_item_type item;
      int           pick;
      pick = $urandom_range(0, 99);
      item.opcode = (pick < 40) ? OP_READ :
                    (pick < 80) ? OP_WRITE :
                    (pick < 90) ? OP_WRITE_ALIGN : OP_READ_ALIGN;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         item.bit_index = 15'($urandom_range(0, HOT_SPAN - 1));
      else if (pick < 8)
         item.bit_index = 15'($urandom_range(STORE_BITS - HOT_SPAN, STORE_BITS - 1));
      else
         item.bit_index = 15'($urandom_range(0, STORE_BITS - 1));
      item.bit_count = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, FIELD_MAX))
                                                  : 6'($urandom_range(FIELD_MAX + 1, 63));
      item.write_value = $urandom;
      return item;
   endfunction

   // Field writes and reads: full width, zero count, oversized count, odd offsets
   task automatic test_field_access();
      send_op(OP_WRITE, 0, 32, 32'hDEAD_BEEF);
      send_op(OP_READ, 0, 32, 32'h0);
      send_op(OP_WRITE, 5, 0, 32'hFFFF_FFFF);
      send_op(OP_READ, 3, 0, 32'hFFFF_FFFF);
      send_op(OP_WRITE, 37, 63, 32'hA5A5_5A5A);
      send_op(OP_READ, 37, 40, 32'h0);
      send_op(OP_WRITE, 100, 1, 32'h0000_0001);
      send_op(OP_READ, 100, 1, 32'h0);
      send_op(OP_WRITE, 203, 13, 32'hFFFF_FFFF);
      send_op(OP_READ, 200, 32, 32'h0);
   endtask

   // Alignment ops: zero pad, round up only, already aligned, ignored fields
   task automatic test_alignment();
      send_op(OP_WRITE_ALIGN, 211, 63, 32'hFFFF_FFFF);
      send_op(OP_READ, 200, 16, 32'h0);
      send_op(OP_READ_ALIGN, 213, 17, 32'hFFFF_FFFF);
      send_op(OP_WRITE_ALIGN, 216, 32, 32'hFFFF_FFFF);
      send_op(OP_READ_ALIGN, 0, 0, 32'h0);
   endtask

   // Accesses at and just past the top of the store
   task automatic test_store_end();
      send_op(OP_WRITE, STORE_BITS - 32, 32, 32'hFFFF_FFFF);
      send_op(OP_READ, STORE_BITS - 32, 32, 32'h0);
      send_op(OP_WRITE, STORE_BITS - 31, 32, 32'h0);
      send_op(OP_READ, STORE_BITS - 1, 1, 32'h0);
      send_op(OP_READ, STORE_BITS - 1, 2, 32'h0);
      send_op(OP_READ, STORE_BITS - 1, 0, 32'h0);
      send_op(OP_WRITE_ALIGN, STORE_BITS - 1, 0, 32'hFFFF_FFFF);
      send_op(OP_READ_ALIGN, STORE_BITS - 1, 0, 32'h0);
      send_op(OP_READ, STORE_BITS - 8, 8, 32'h0);
   endtask

   // Random traffic; about half of the writes are followed by a read of the same field
   task automatic test_random_traffic(input int num_items, input int idle_pct,
                                      input int stall_pct);
      req_item_type item;
      int           sent;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < num_items) begin
         item = random_access();
         send_item(item);
         sent++;
         if (item.opcode == OP_WRITE && $urandom_range(0, 1) == 1) begin
            item.opcode = OP_READ;
            send_item(item);
            sent++;
         end
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure(input int num_items);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            repeat (num_items) send_item(random_access());
         end
      join
   endtask

   // Response-side stall
   always @(negedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            oldest_expected = pending_results.pop_front();
            if (rsp_data.read_value !== oldest_expected.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        oldest_expected.read_value, rsp_data.read_value);
               error_count++;
            end
            if (rsp_data.next_index !== oldest_expected.next_index) begin
               $display("%0t: next_index expected %0d actual %0d", $time,
                        oldest_expected.next_index, rsp_data.next_index);
               error_count++;
            end
            if (rsp_data.out_of_range !== oldest_expected.out_of_range) begin
               $display("%0t: out_of_range expected %b actual %b", $time,
                        oldest_expected.out_of_range, rsp_data.out_of_range);
               error_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      for (int b = 0; b < STORE_BYTES; b++) shadow_store[b] = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_access();
      test_alignment();
      test_store_end();
      test_random_traffic(500, 17, 80);
      test_random_traffic(500, 80, 17);
      test_random_traffic(480, 0, 0);
      test_backpressure(60);
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS bit_field_insert_extract_store");
      end else begin
         $display("FAIL bit_field_insert_extract_store");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAIL bit_field_insert_extract_store");
      $finish;
   end

endmodule
